// ===== hdl/icon_alpha_blend_pixel_unit_defines.svh =====
// assertion macros shared by the icon alpha blend pixel unit
`ifndef ICON_ALPHA_BLEND_PIXEL_UNIT_DEFINES_SVH
`define ICON_ALPHA_BLEND_PIXEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define ABP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked from one edge to the next, outside reset
`define ABP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define ABP_ASSERT(label, prop, msg)
`define ABP_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

// ===== hdl/abp_pkg.sv =====
// shared constants, types and helpers of the icon alpha blend pixel unit
`timescale 1ns / 1ps

package abp_pkg;

  // size limits
  localparam int MAX_FRAME_DIM = 4096;
  localparam int MAX_ICON_SIDE = 256;

  // fixed field widths
  localparam int COORD_W     = 13;
  localparam int SIDE_W      = 9;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int POS_IN_W    = 8;
  localparam int ADDR_W      = 24;
  localparam int PIX_W       = 32;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int MIX_W       = 2 * CH_W;

  // derived widths
  localparam int DIM_W    = $clog2(MAX_FRAME_DIM + 1);
  localparam int POS_W    = $clog2(MAX_FRAME_DIM);
  localparam int TGT_W    = COORD_W + 1;
  localparam int APROD_W  = POS_W + DIM_W;
  localparam int ASUM_W   = (APROD_W + 1 > ADDR_W) ? APROD_W + 1 : ADDR_W;

  localparam logic [CH_W-1:0] ALPHA_FULL = {CH_W{1'b1}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ICON_SIDE    = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } cfg_reg_t;

  // configuration after clamping to the size limits
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SIDE_W-1:0]  side;
    logic [DIM_W-1:0]   fw;
    logic [DIM_W-1:0]   fh;
  } cfg_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [MIX_W-1:0] x);
    logic [MIX_W:0] t;
    t = (MIX_W + 1)'(x) + (MIX_W + 1)'(1) + (MIX_W + 1)'(x >> CH_W);
    return t[MIX_W-1:CH_W];
  endfunction

endpackage

// ===== hdl/abp_cfg.sv =====
// configuration registers with clamping to the size limits
`timescale 1ns / 1ps

module abp_cfg import abp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [SIDE_W-1:0]  icon_side;
  logic [COORD_W-1:0] frame_width;
  logic [COORD_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      icon_side    <= SIDE_W'(32);
      frame_width  <= COORD_W'(640);
      frame_height <= COORD_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:     origin_x     <= cfg_data;
        REG_ORIGIN_Y:     origin_y     <= cfg_data;
        REG_ICON_SIDE:    icon_side    <= cfg_data[SIDE_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.origin_x = origin_x;
    cfg.origin_y = origin_y;
    cfg.side = (32'(icon_side) > MAX_ICON_SIDE) ? SIDE_W'(MAX_ICON_SIDE) : icon_side;
    cfg.fw = (32'(frame_width) > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM)
                                                 : DIM_W'(frame_width);
    cfg.fh = (32'(frame_height) > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM)
                                                  : DIM_W'(frame_height);
  end

endmodule

// ===== hdl/abp_geom.sv =====
// clip test and linear address pipeline, three register stages
`timescale 1ns / 1ps

module abp_geom import abp_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  cfg_t                cfg,
  input  logic [POS_IN_W-1:0] column,
  input  logic [POS_IN_W-1:0] line,
  input  logic [CH_W-1:0]     alpha,
  output logic                write_enable,
  output logic [ADDR_W-1:0]   pixel_address
);

  logic signed [TGT_W-1:0] px;
  logic signed [TGT_W-1:0] py;
  logic                    hit;

  logic               s1_we;
  logic [POS_W-1:0]   s1_px;
  logic [POS_W-1:0]   s1_py;
  logic [DIM_W-1:0]   s1_fw;
  logic               s2_we;
  logic [POS_W-1:0]   s2_px;
  logic [APROD_W-1:0] s2_prod;
  logic [ASUM_W-1:0]  addr_sum;

  // target position, clip against icon and frame, and zero-alpha test
  always_comb begin
    px = TGT_W'($signed(cfg.origin_x)) + $signed({1'b0, column});
    py = TGT_W'($signed(cfg.origin_y)) + $signed({1'b0, line});
    hit = (SIDE_W'(column) < cfg.side) && (SIDE_W'(line) < cfg.side) &&
          (alpha != '0) && !px[TGT_W-1] && !py[TGT_W-1] &&
          (32'(px[TGT_W-2:0]) < 32'(cfg.fw)) &&
          (32'(py[TGT_W-2:0]) < 32'(cfg.fh));
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      s1_we <= hit;
      s1_px <= px[POS_W-1:0];
      s1_py <= py[POS_W-1:0];
      s1_fw <= cfg.fw;
    end
    if (en.en2) begin
      s2_we   <= s1_we;
      s2_px   <= s1_px;
      s2_prod <= APROD_W'(s1_py) * APROD_W'(s1_fw);
    end
    if (en.en3) begin
      write_enable  <= s2_we;
      pixel_address <= s2_we ? addr_sum[ADDR_W-1:0] : '0;
    end
  end

  assign addr_sum = ASUM_W'(s2_prod) + ASUM_W'(s2_px);

endmodule

// ===== hdl/abp_blend.sv =====
// per-channel blend pipeline, three register stages
`timescale 1ns / 1ps

module abp_blend import abp_pkg::*; (
  input  logic             clk,
  input  stage_en_t        en,
  input  logic [PIX_W-1:0] src_pixel,
  input  logic [PIX_W-1:0] dst_pixel,
  output logic [PIX_W-1:0] pixel
);

  logic [CH_W-1:0]  alpha;
  logic [CH_W-1:0]  alpha_inv;

  logic             s1_full;
  logic [PIX_W-1:0] s1_src;
  logic [MIX_W-1:0] s1_ps [NUM_CH];
  logic [MIX_W-1:0] s1_pd [NUM_CH];
  logic             s2_full;
  logic [PIX_W-1:0] s2_src;
  logic [MIX_W-1:0] s2_sum [NUM_CH];
  logic [PIX_W-1:0] mixed;

  assign alpha     = src_pixel[PIX_W-1 -: CH_W];
  assign alpha_inv = ALPHA_FULL - alpha;

  always_ff @(posedge clk) begin
    if (en.en1) begin
      s1_full <= (alpha == ALPHA_FULL);
      s1_src  <= src_pixel;
      for (int c = 0; c < NUM_CH; c++) begin
        s1_ps[c] <= MIX_W'(src_pixel[c*CH_W +: CH_W]) * MIX_W'(alpha);
        s1_pd[c] <= MIX_W'(dst_pixel[c*CH_W +: CH_W]) * MIX_W'(alpha_inv);
      end
    end
    if (en.en2) begin
      s2_full <= s1_full;
      s2_src  <= s1_src;
      for (int c = 0; c < NUM_CH; c++) begin
        s2_sum[c] <= s1_ps[c] + s1_pd[c];
      end
    end
    if (en.en3) begin
      pixel <= s2_full ? s2_src : mixed;
    end
  end

  // divide by 255 and force opaque alpha
  always_comb begin
    mixed = '0;
    mixed[PIX_W-1 -: CH_W] = ALPHA_FULL;
    for (int c = 0; c < NUM_CH; c++) begin
      mixed[c*CH_W +: CH_W] = div255(s2_sum[c]);
    end
  end

endmodule

// ===== hdl/icon_alpha_blend_pixel_unit.sv =====
// top level of the icon alpha blend pixel unit
`timescale 1ns / 1ps
`include "icon_alpha_blend_pixel_unit_defines.svh"

// alpha blends ARGB8888 icon pixels, one per clock while in_stall is low,
// over the framebuffer pixel at its target position. the target is origin
// plus icon column and row; it is clipped to the icon size and the frame,
// and source alpha zero gives no write. a pixel with write_enable low
// carries zero address and pixel. throughput is one item per clock while
// in_stall is low; the three stages up to the result register are: clip
// test and channel products, row address product and channel sums, then the
// divide by 255 with final address add. out_stall backs up through the stage
// valid bits, and in_stall rises only when every stage holds an item and the
// output is stalled. config takes effect on items accepted after the write.
module icon_alpha_blend_pixel_unit import abp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input item channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [POS_IN_W-1:0]    column,
  input  logic [POS_IN_W-1:0]    line,
  input  logic [PIX_W-1:0]       src_pixel,
  input  logic [PIX_W-1:0]       dst_pixel,
  // result item channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   write_enable,
  output logic [ADDR_W-1:0]      pixel_address,
  output logic [PIX_W-1:0]       out_pixel
);

  cfg_t      cfg;
  stage_en_t en;

  // stage valid bits; stage three is the output register
  logic v1;
  logic v2;
  logic v3;
  logic ready1;
  logic ready2;
  logic ready3;

  logic [PIX_W-1:0] pixel;

  abp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage may load when it is empty or its item moves on this edge
  assign ready3 = !v3 || !out_stall;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  assign en.en1 = ready1;
  assign en.en2 = ready2;
  assign en.en3 = ready3;

  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  abp_geom u_geom (
    .clk           (clk),
    .en            (en),
    .cfg           (cfg),
    .column        (column),
    .line          (line),
    .alpha         (src_pixel[PIX_W-1 -: CH_W]),
    .write_enable  (write_enable),
    .pixel_address (pixel_address)
  );

  abp_blend u_blend (
    .clk       (clk),
    .en        (en),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .pixel     (pixel)
  );

  assign out_valid = v3;

  // no-write results carry a zero pixel
  assign out_pixel = write_enable ? pixel : '0;

  `ABP_ASSERT(a_stall_only_when_full, !in_stall || (v1 && v2 && v3 && out_stall), "input stalled with room in the pipeline")
  `ABP_ASSERT(a_write_has_alpha, !(out_valid && write_enable) || (out_pixel[PIX_W-1 -: CH_W] != '0), "write with zero output alpha")
  `ABP_ASSERT(a_nowrite_zero, !(out_valid && !write_enable) || (pixel_address == '0), "no-write result with nonzero address")
  `ABP_ASSERT_NEXT(a_mid_stage_kept, v2 && !ready3, v2, "stage two item dropped while blocked")

endmodule
